### design/spm_pkg.sv
// spm_pkg: shared constants for the stream pattern masker
// register indexes, mask character and default window depth; no dependencies
`timescale 1ns / 1ps

package spm_pkg;

  localparam int MAX_PATTERN = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam int PLEN_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 1'd1;

  localparam logic [7:0] MASK_CHAR = 8'h2A;

endpackage

### design/stream_pattern_masker.sv
// stream_pattern_masker: masks every occurrence of a byte pattern with asterisks
// depends on spm_pkg
`timescale 1ns / 1ps

// Text enters one byte per word on the s_axis channel; tlast marks the end of
// the text. Masked text leaves one byte per word on m_axis; tlast marks the
// last word caused by an input word, tuser marks the last word of the text.
// The pattern (up to MaxPattern bytes, first byte lowest) and its length are
// set through the write port while the block is idle; length zero passes the
// text through unchanged.
// A word that completes a window is compared and, when the output register is
// free, its first result is loaded into the output register in the same cycle
// as the word is taken. While a word still has compare or flush work behind
// its current result no further word is taken, so such a word holds the input
// off until its last result is loaded. A hit emits pattern-length asterisks,
// one per cycle from a star counter while the receiver is ready, and further
// words that cannot complete the window are taken during that run. An end-of-text
// word flushes the window one byte per cycle while the receiver is ready.
// Unstalled rate is one word per cycle, set by the single output register.
// Reset empties the window and the output register; the pattern registers
// clear to zero. A stalled receiver holds the output word and the block stops
// taking words as soon as a taken word would need an output slot.
module stream_pattern_masker #(
  parameter int MaxPattern = spm_pkg::MAX_PATTERN
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // text_byte
  input  logic                          s_axis_tlast,   // end_of_text
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // out_byte
  output logic                          m_axis_tlast,   // run_last
  output logic                          m_axis_tuser    // text_done
);
  import spm_pkg::*;

  localparam int CntW = $clog2(MaxPattern + 1);
  localparam int IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int WinW = MaxPattern * 8;

  logic [CFG_DATA_W-1:0] pat_q;
  logic [PLEN_W-1:0]     plen_q;
  logic [CntW-1:0]       len;

  logic [WinW-1:0] win_q, win_a, win_d;
  logic [CntW-1:0] cnt_q, cnt_a, cnt_d;
  logic [CntW-1:0] star_q, star_d;
  logic            act_q, act_a, act_d;
  logic            eot_q, eot_a;
  logic            fin_q, fin_d;
  logic            seot_q, seot_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_done_q, out_done_d;

  logic            in_acc, out_free, emit, hit, busy, more_n;
  logic [IdxW-1:0] idx;

  function automatic logic more(logic [CntW-1:0] cnt, logic eot, logic [CntW-1:0] plen);
    if (plen == '0) begin
      more = (cnt != '0);
    end else begin
      more = (cnt >= plen) || (eot && (cnt != '0));
    end
  endfunction

  assign len = (plen_q > PLEN_W'(MaxPattern)) ? CntW'(MaxPattern) : plen_q[CntW-1:0];

  assign busy = (act_q && more(cnt_q, eot_q, len)) ||
                ((star_q != '0) && !(({1'b0, cnt_q} + (CntW+1)'(1)) < {1'b0, len}));
  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    win_a = win_q;
    cnt_a = cnt_q;
    act_a = act_q;
    eot_a = eot_q;
    idx   = '0;
    if (in_acc) begin
      idx = (cnt_q >= CntW'(MaxPattern)) ? IdxW'(MaxPattern - 1) : cnt_q[IdxW-1:0];
      for (int i = 0; i < MaxPattern; i++) begin
        if (idx == IdxW'(i)) begin
          win_a[i*8 +: 8] = s_axis_tdata;
        end
      end
      cnt_a = CntW'(idx) + CntW'(1);
      act_a = 1'b1;
      eot_a = s_axis_tlast;
    end

    hit = 1'b1;
    for (int i = 0; i < MaxPattern; i++) begin
      if ((CntW'(i) < len) && (win_a[i*8 +: 8] != pat_q[i*8 +: 8])) begin
        hit = 1'b0;
      end
    end

    win_d      = win_a;
    cnt_d      = cnt_a;
    star_d     = star_q;
    fin_d      = fin_q;
    seot_d     = seot_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    more_n     = 1'b0;

    emit = out_free && ((star_q != '0) || (act_a && more(cnt_a, eot_a, len)));

    if (emit) begin
      if (star_q != '0) begin
        out_byte_d = MASK_CHAR;
        star_d     = star_q - CntW'(1);
        out_last_d = (star_d == '0) && fin_q;
        out_done_d = out_last_d && seot_q;
      end else if ((len == '0) || (cnt_a < len) || !hit) begin
        out_byte_d = win_a[7:0];
        win_d      = win_a >> 8;
        cnt_d      = cnt_a - CntW'(1);
        more_n     = more(cnt_d, eot_a, len);
        out_last_d = !more_n;
        out_done_d = out_last_d && eot_a;
      end else begin
        out_byte_d = MASK_CHAR;
        win_d      = win_a >> {len, 3'b000};
        cnt_d      = cnt_a - len;
        star_d     = len - CntW'(1);
        more_n     = more(cnt_d, eot_a, len);
        fin_d      = !more_n;
        seot_d     = eot_a;
        out_last_d = (star_d == '0) && !more_n;
        out_done_d = out_last_d && eot_a;
      end
    end

    act_d = act_a && more(cnt_d, eot_a, len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATTERN_BYTES: pat_q  <= cfg_data_i;
        REG_PATTERN_LEN:   plen_q <= cfg_data_i[PLEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      star_q      <= '0;
      act_q       <= 1'b0;
      eot_q       <= 1'b0;
      fin_q       <= 1'b0;
      seot_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      star_q <= star_d;
      act_q  <= act_d;
      eot_q  <= eot_a;
      fin_q  <= fin_d;
      seot_q <= seot_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  // end of text is always the last word of its run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("text_done without run_last");

  // window never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxPattern))
    else $error("window count overflow");

  // the star counter always stays below the window depth
  a_star_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    star_q < CntW'(MaxPattern))
    else $error("star count overflow");

  // while a hit still has loop work behind it no new word is taken
  a_star_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (star_q != '0) && !fin_q |-> !s_axis_tready)
    else $error("word taken during unfinished match run");

endmodule

### bench/testbench.sv
// testbench: directed and randomized check of stream_pattern_masker
// predicts the masked text with its own window model; depends on spm_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import spm_pkg::*;

  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 9;
  localparam int PHASE_BYTES     = 22;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } masked_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  // mirror of the block's registers and window
  logic [63:0]  pat_bytes_m = '0;
  logic [3:0]   pat_len_m = '0;
  logic [7:0]   window_q[$];
  masked_word_t masked_q[$];
  masked_word_t head_w;

  int  mismatch_count = 0;
  int  stall_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  stream_pattern_masker u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),   // text_byte
    .s_axis_tlast (s_tlast),   // end_of_text
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),   // out_byte
    .m_axis_tlast (m_tlast),   // run_last
    .m_axis_tuser (m_tuser)    // text_done
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int idle_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_len(input logic [3:0] plen);
    return (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
  endfunction

  // leftmost-first, non-overlapping masking of one text byte
  function automatic void predict_masking(input logic [7:0] b, input logic eot);
    masked_word_t run_q[$];
    masked_word_t w;
    int           len;
    int           i;
    bit           hit;
    len = eff_len(pat_len_m);
    while (window_q.size() >= MAX_PATTERN) void'(window_q.pop_back());
    window_q.push_back(b);
    w = '0;
    if (len == 0) begin
      while (window_q.size() > 0) begin
        w.out_byte = window_q.pop_front();
        run_q.push_back(w);
      end
    end else begin
      while (window_q.size() >= len) begin
        hit = 1'b1;
        for (i = 0; i < len; i++) begin
          if (window_q[i] != pat_bytes_m[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < len; i++) begin
            void'(window_q.pop_front());
            w.out_byte = MASK_CHAR;
            run_q.push_back(w);
          end
        end else begin
          w.out_byte = window_q.pop_front();
          run_q.push_back(w);
        end
      end
      if (eot) begin
        while (window_q.size() > 0) begin
          w.out_byte = window_q.pop_front();
          run_q.push_back(w);
        end
      end
    end
    if (run_q.size() > 0) begin
      w = run_q.pop_back();
      w.run_last  = 1'b1;
      w.text_done = eot;
      run_q.push_back(w);
    end
    foreach (run_q[k]) masked_q.push_back(run_q[k]);
  endfunction

  task automatic send_text_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = idle_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_masking(b, eot);
  endtask

  task automatic send_pattern_prefix(input int count);
    int i;
    for (i = 0; i < count; i++) send_text_byte(pat_bytes_m[8*i +: 8], 1'b0);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (masked_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pattern(input logic [63:0] bytes, input logic [3:0] plen);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_PATTERN_BYTES;
    cfg_data <= bytes;
    @(posedge clk);
    cfg_idx  <= REG_PATTERN_LEN;
    cfg_data <= {{(CFG_DATA_W-PLEN_W){1'b0}}, plen};
    @(posedge clk);
    cfg_we <= 1'b0;
    pat_bytes_m = bytes;
    pat_len_m   = plen;
  endtask

  // empty pattern after reset: text passes straight through
  task automatic test_reset_passthrough();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(MASK_CHAR, 1'b1);
    wait_idle();
  endtask

  // length above the window saturates to the full window
  task automatic test_saturated_length();
    set_pattern(64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
    send_pattern_prefix(MAX_PATTERN);
    send_text_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_single_zero_byte();
    set_pattern(64'h0, 4'd1);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h41, 1'b0);
    send_text_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  // "aab" masks only the second pair; a lone byte at end of text is flushed
  task automatic test_leftmost_match();
    set_pattern(64'h6261, 4'd2);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b1);
    send_text_byte(8'h61, 1'b1);
    wait_idle();
  endtask

  // window keeps its bytes across a pattern change
  task automatic test_pattern_change();
    set_pattern(64'h63_6261, 4'd3);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b0);
    wait_idle();
    set_pattern(64'h7978, 4'd2);
    send_text_byte(8'h7A, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_texts();
    int          phase;
    int          sent;
    int          len;
    int          pick;
    int          i;
    logic [63:0] pat;
    logic [3:0]  plen;
    logic [7:0]  alpha0;
    logic [7:0]  alpha1;
    logic [7:0]  b;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: plen = 4'd8;
        1: plen = 4'd0;
        2: plen = 4'd15;
        3: plen = 4'd1;
        default: begin
          plen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(1, 8));
        end
      endcase
      alpha0 = 8'($urandom());
      alpha1 = 8'($urandom());
      pat = {$urandom(), $urandom()};
      if (phase % 2 == 0) begin
        for (i = 0; i < MAX_PATTERN; i++) pat[8*i +: 8] = $urandom_range(0, 1) ? alpha0 : alpha1;
      end
      quiet = (phase == 4);
      set_pattern(pat, plen);
      if (phase == 5) hold_req = 1'b1;
      len = eff_len(plen);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(0, 9);
        if (pick < 4 && len > 0) begin
          send_pattern_prefix(len);
          sent += len;
        end else if (pick < 6 && len > 1) begin
          i = $urandom_range(1, len - 1);
          send_pattern_prefix(i);
          sent += i;
        end else begin
          b = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? alpha0 : alpha1) : 8'($urandom());
          send_text_byte(b, 1'b0);
          sent++;
        end
        if ($urandom_range(0, 7) == 0) begin
          send_text_byte(8'($urandom()), 1'b1);
          sent++;
        end
      end
      send_text_byte(8'($urandom()), 1'b1);
      wait_idle();
    end
    quiet = 1'b0;
  endtask

  // receiver: random stalls, quiet stretches and one long hold-off
  initial begin : receiver
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = idle_gap();
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (masked_q.size() == 0) begin
        $display("%0t: unexpected word: actual byte=%h last=%b done=%b",
                 $time, m_tdata, m_tlast, m_tuser);
        mismatch_count++;
      end else begin
        head_w = masked_q.pop_front();
        if (head_w.out_byte !== m_tdata || head_w.run_last !== m_tlast ||
            head_w.text_done !== m_tuser) begin
          $display("%0t: mismatch: expected byte=%h last=%b done=%b, actual byte=%h last=%b done=%b",
                   $time, head_w.out_byte, head_w.run_last, head_w.text_done,
                   m_tdata, m_tlast, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d words still expected", $time, masked_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_passthrough();
    test_saturated_length();
    test_single_zero_byte();
    test_leftmost_match();
    test_pattern_change();
    test_random_texts();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
